// ----- src/tmtw_pkg.sv -----
// Shared types and constants for the text-mode terminal writer.
// No dependencies; imported by tmtw_ctrl, tmtw_datapath and the top level.
`default_nettype none

package tmtw_pkg;

    // Field widths fixed by the interface
    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = 16;
    localparam int RCOL_W  = 7;
    localparam int RROW_W  = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    // Attribute after reset
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;          // latch the input transaction
        logic exec;          // carry out the latched operation
        logic sweep_clear;   // one step of the zero-fill pass
        logic sweep_scroll;  // one step of the scroll pass
        logic emit;          // present the result transaction
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic op_clear;
        logic op_read;
        logic need_scroll;
        logic sweep_last;
    } stat_t;

endpackage

`default_nettype wire

// ----- src/text_mode_terminal_writer_top.sv -----
// Top level of the text-mode terminal writer console.
// Depends on tmtw_pkg, tmtw_ctrl and tmtw_datapath.
//
// A transaction is taken on a clock edge with start high and busy low; each
// transaction gives one result, held on the result ports for exactly one
// cycle with result_valid high, and the receiver cannot stall it. A cell read
// also passes through the read state, for the registered read of the screen
// memory. Clear and a put that scrolls run one pass over the screen memory
// (one write port, one registered read port), one cell per cycle. After
// reset the block is busy while that pass zeroes the screen; the attribute
// can be written at any time the block is idle, through cfg_we and cfg_wdata.
`default_nettype none

module text_mode_terminal_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [tmtw_pkg::OP_W-1:0]    operation,
    input  wire logic [tmtw_pkg::CHAR_W-1:0]  char_code,
    input  wire logic [tmtw_pkg::RCOL_W-1:0]  read_column,
    input  wire logic [tmtw_pkg::RROW_W-1:0]  read_row,
    input  wire logic                         cfg_we,
    input  wire logic [tmtw_pkg::ATTR_W-1:0]  cfg_wdata,
    output logic                              result_valid,
    output logic [tmtw_pkg::CELL_W-1:0]       cell_value,
    output logic [tmtw_pkg::RCOL_W-1:0]       cursor_column,
    output logic [tmtw_pkg::RROW_W-1:0]       cursor_row
);
    import tmtw_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Controller
    tmtw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Datapath
    tmtw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (operation),
        .char_code     (char_code),
        .read_column   (read_column),
        .read_row      (read_row),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .result_valid  (result_valid),
        .cell_value    (cell_value),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row)
    );

endmodule

`default_nettype wire

// ----- src/tmtw_ctrl.sv -----
// Controller state machine of the text-mode terminal writer.
// Depends on tmtw_pkg (cmd_t, stat_t).
`default_nettype none

module tmtw_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  tmtw_pkg::stat_t      stat,
    output tmtw_pkg::cmd_t       cmd
);
    import tmtw_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL
    } state_t;

    state_t state_reg, state_next;
    logic   report_reg, report_next;

    // Next state and command decode
    always_comb
    begin
        state_next  = state_reg;
        report_next = report_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep_clear = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.emit   = report_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.op_clear)
                begin
                    report_next = 1'b1;
                    state_next  = ST_CLEAR;
                end
                else if (stat.op_read)
                begin
                    state_next = ST_READ;
                end
                else if (stat.need_scroll)
                begin
                    state_next = ST_SCROLL;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCROLL:
            begin
                cmd.sweep_scroll = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register; the pass after reset reports nothing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            report_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            report_reg <= report_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ----- src/tmtw_datapath.sv -----
// Datapath of the text-mode terminal writer: screen memory, cursor,
// attribute register, input latch, sweep counter and result registers.
// Depends on tmtw_pkg (cmd_t, stat_t, codes and widths).
`default_nettype none

module tmtw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  tmtw_pkg::cmd_t                    cmd,
    output tmtw_pkg::stat_t                   stat,
    input  wire logic [tmtw_pkg::OP_W-1:0]    operation,
    input  wire logic [tmtw_pkg::CHAR_W-1:0]  char_code,
    input  wire logic [tmtw_pkg::RCOL_W-1:0]  read_column,
    input  wire logic [tmtw_pkg::RROW_W-1:0]  read_row,
    input  wire logic                         cfg_we,
    input  wire logic [tmtw_pkg::ATTR_W-1:0]  cfg_wdata,
    output logic                              result_valid,
    output logic [tmtw_pkg::CELL_W-1:0]       cell_value,
    output logic [tmtw_pkg::RCOL_W-1:0]       cursor_column,
    output logic [tmtw_pkg::RROW_W-1:0]       cursor_row
);
    import tmtw_pkg::*;

    localparam int TOTAL   = COLUMNS * ROWS;
    localparam int TOP     = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W  = $clog2(TOTAL);
    localparam int SWEEP_W = $clog2(TOTAL + 1);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);

    localparam logic [COL_W-1:0]   COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]   ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [SWEEP_W-1:0] SWEEP_END  = SWEEP_W'(TOTAL);
    localparam logic [SWEEP_W-1:0] SWEEP_TOP  = SWEEP_W'(TOP);
    localparam logic [SWEEP_W:0]   SWEEP_STEP = (SWEEP_W + 1)'(COLUMNS);

    // Screen memory
    logic [CELL_W-1:0] mem [TOTAL];
    logic [CELL_W-1:0] rdata_reg;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [CELL_W-1:0] wdata;

    // Latched transaction
    logic [OP_W-1:0]   op_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic [RCOL_W-1:0] rc_reg;
    logic [RROW_W-1:0] rr_reg;
    logic              rd_ok_reg;

    // Architectural state
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [ATTR_W-1:0]  attr_reg;
    logic [SWEEP_W-1:0] sweep_reg;
    logic               valid_reg;
    logic [CELL_W-1:0]  cell_reg;

    // Put decode
    logic is_put, is_nl, is_bs, is_cr, is_plain, col_end, row_end;
    logic put_writes;
    logic [COL_W-1:0]  wcol;
    logic [ADDR_W-1:0] cur_addr, rd_addr, scroll_raddr;
    logic [SWEEP_W:0]  scroll_sum;
    logic              sweeping;

    assign is_put   = (op_reg == OP_PUT);
    assign is_nl    = (ch_reg == CH_NEWLINE);
    assign is_bs    = (ch_reg == CH_BACKSPACE) && (col_reg != '0);
    assign is_cr    = (ch_reg == CH_RETURN);
    assign is_plain = !is_nl && !is_bs && !is_cr;
    assign col_end  = (col_reg == COL_LAST);
    assign row_end  = (row_reg == ROW_LAST);
    assign put_writes = is_put && (is_bs || is_plain);
    assign wcol     = is_bs ? (col_reg - 1'b1) : col_reg;
    assign cur_addr = ADDR_W'(row_reg * COLUMNS + wcol);
    assign rd_addr  = rd_ok_reg ? ADDR_W'(rr_reg * COLUMNS + rc_reg) : '0;
    assign sweeping = cmd.sweep_clear || cmd.sweep_scroll;

    // Scroll reads one row ahead of the write
    assign scroll_sum   = {1'b0, sweep_reg} + SWEEP_STEP;
    assign scroll_raddr = ADDR_W'(scroll_sum);

    // Status to controller
    always_comb
    begin
        stat.op_clear    = (op_reg == OP_CLEAR);
        stat.op_read     = (op_reg == OP_READ);
        stat.need_scroll = is_put && row_end && (is_nl || (is_plain && col_end));
        stat.sweep_last  = (sweep_reg == SWEEP_END);
    end

    // Memory port selection
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (cmd.exec && put_writes)
        begin
            we    = 1'b1;
            waddr = cur_addr;
            wdata = {attr_reg, (is_bs ? CH_SPACE : ch_reg)};
        end
        else if (sweeping && (sweep_reg != '0))
        begin
            we    = 1'b1;
            waddr = ADDR_W'(sweep_reg - 1'b1);
            if (cmd.sweep_clear)
                wdata = '0;
            else if (sweep_reg <= SWEEP_TOP)
                wdata = rdata_reg;
            else
                wdata = {attr_reg, CH_SPACE};
        end

        if (cmd.sweep_scroll && (sweep_reg < SWEEP_TOP))
            raddr = scroll_raddr;
        else
            raddr = rd_addr;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // Cursor update
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.exec)
        begin
            if (op_reg == OP_CLEAR)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (is_put)
            begin
                if (is_nl || (is_plain && col_end))
                begin
                    col_next = '0;
                    if (!row_end)
                        row_next = row_reg + 1'b1;
                end
                else if (is_bs)
                    col_next = col_reg - 1'b1;
                else if (is_plain)
                    col_next = col_reg + 1'b1;
            end
        end
    end

    // Input latch and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= operation;
            ch_reg    <= char_code;
            rc_reg    <= read_column;
            rr_reg    <= read_row;
            rd_ok_reg <= (read_column < COLUMNS) && (read_row < ROWS);
        end
        if (cmd.emit)
            cell_reg <= (stat.op_read && rd_ok_reg) ? rdata_reg : '0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            attr_reg  <= ATTR_RESET;
            sweep_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            valid_reg <= cmd.emit;
            if (cfg_we)
                attr_reg <= cfg_wdata;
            if (sweeping)
                sweep_reg <= stat.sweep_last ? '0 : sweep_reg + 1'b1;
        end
    end

    assign result_valid  = valid_reg;
    assign cell_value    = cell_reg;
    assign cursor_column = RCOL_W'(col_reg);
    assign cursor_row    = RROW_W'(row_reg);

endmodule

`default_nettype wire

// ----- sim/text_mode_terminal_writer_top_test.sv -----
// Self-checking testbench for the text-mode terminal writer console.
// Depends on tmtw_pkg and text_mode_terminal_writer_top; keeps its own screen
// model and checks cursor and cell of every result transaction.
`default_nettype none

module text_mode_terminal_writer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tmtw_pkg::*;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = COLUMNS * ROWS;
    localparam int CLK_PERIOD = 4;
    localparam int RESET_CYC  = 6;
    localparam int TAIL_CYC   = CELLS + 8;
    localparam int PHASES     = 6;
    localparam int PHASE_OPS  = 180;
    localparam int SHOWN_ERRS = 10;

    // Operation code the block leaves unused
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef enum logic [1:0] {
        STEP_OP,
        STEP_CFG,
        STEP_GAP
    } step_kind_e;

    // One entry of the stimulus queue
    typedef struct packed {
        step_kind_e           kind;
        logic [OP_W-1:0]      operation;
        logic [CHAR_W-1:0]    char_code;
        logic [RCOL_W-1:0]    read_column;
        logic [RROW_W-1:0]    read_row;
        logic [ATTR_W-1:0]    attr;
        logic [1:0]           gap;
    } console_step_t;

    // What one result transaction carries
    typedef struct packed {
        logic [CELL_W-1:0] cell_val;
        logic [RCOL_W-1:0] col;
        logic [RROW_W-1:0] row;
    } console_view_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic [OP_W-1:0]     operation   = OP_PUT;
    logic [CHAR_W-1:0]   char_code   = '0;
    logic [RCOL_W-1:0]   read_column = '0;
    logic [RROW_W-1:0]   read_row    = '0;
    logic                cfg_we      = 1'b0;
    logic [ATTR_W-1:0]   cfg_wdata   = '0;
    logic                busy;
    logic                result_valid;
    logic [CELL_W-1:0]   cell_value;
    logic [RCOL_W-1:0]   cursor_column;
    logic [RROW_W-1:0]   cursor_row;

    // Screen model
    logic [CELL_W-1:0]   screen_model [0:CELLS-1];
    int                  cur_col;
    int                  cur_row;
    logic [ATTR_W-1:0]   attr_model;

    console_step_t       console_cmds [$];
    console_view_t       expected_views [$];
    console_step_t       head_cmd;
    console_view_t       want_view;
    console_view_t       seen_view;
    logic                took_item    = 1'b0;
    int                  hold_cycles  = 0;
    int                  ops_queued   = 0;
    int                  mismatches   = 0;
    int                  cycle_count  = 0;
    int                  cycle_limit  = 32'h7fff_ffff;

    text_mode_terminal_writer_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .char_code     (char_code),
        .read_column   (read_column),
        .read_row      (read_row),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .result_valid  (result_valid),
        .cell_value    (cell_value),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------------------------------------------------------
    // Screen model
    // ---------------------------------------------------------------
    task automatic model_clear();
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = '0;
        cur_col = 0;
        cur_row = 0;
    endtask

    // Newline; from the last row the screen scrolls up and the bottom row
    // fills with spaces in the current attribute
    task automatic model_newline();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS)
        begin
            cur_row = ROWS - 1;
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                screen_model[i] = screen_model[i + COLUMNS];
            for (int c = 0; c < COLUMNS; c++)
                screen_model[(ROWS - 1) * COLUMNS + c] = {attr_model, CH_SPACE};
        end
    endtask

    task automatic console_step(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                input logic [RCOL_W-1:0] rc, input logic [RROW_W-1:0] rr,
                                output console_view_t view);
        view.cell_val = '0;
        case (op)
            OP_PUT:
            begin
                if (ch == CH_NEWLINE)
                    model_newline();
                else if (ch == CH_BACKSPACE && cur_col > 0)
                begin
                    cur_col--;
                    screen_model[cur_row * COLUMNS + cur_col] = {attr_model, CH_SPACE};
                end
                else if (ch != CH_RETURN)
                begin
                    // ordinary byte, including a backspace at column zero
                    screen_model[cur_row * COLUMNS + cur_col] = {attr_model, ch};
                    cur_col++;
                    if (cur_col >= COLUMNS)
                        model_newline();
                end
            end
            OP_CLEAR:
                model_clear();
            OP_READ:
                if (int'(rc) < COLUMNS && int'(rr) < ROWS)
                    view.cell_val = screen_model[int'(rr) * COLUMNS + int'(rc)];
            default:
                ;
        endcase
        view.col = RCOL_W'(cur_col);
        view.row = RROW_W'(cur_row);
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] seen_v);
        mismatches++;
        if (mismatches <= SHOWN_ERRS)
            $display("%0t ns: %s mismatch: expected %0h, got %0h", $time, what, want_v, seen_v);
    endtask

    // ---------------------------------------------------------------
    // Stimulus queue builders
    // ---------------------------------------------------------------
    task automatic queue_op(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input logic [RCOL_W-1:0] rc, input logic [RROW_W-1:0] rr,
                            input bit idle_ok);
        console_step_t s;
        if (idle_ok && $urandom_range(0, 9) == 0)
        begin
            s = '0;
            s.kind = STEP_GAP;
            s.gap = 2'($urandom_range(1, 3));
            console_cmds.push_back(s);
        end
        s = '0;
        s.kind = STEP_OP;
        s.operation = op;
        s.char_code = ch;
        s.read_column = rc;
        s.read_row = rr;
        console_cmds.push_back(s);
        if (!(op == OP_NONE || (op == OP_PUT && ch == CH_RETURN)))
            ops_queued++;
    endtask

    task automatic queue_attr(input logic [ATTR_W-1:0] value);
        console_step_t s;
        s = '0;
        s.kind = STEP_CFG;
        s.attr = value;
        console_cmds.push_back(s);
    endtask

    // Mostly on-screen reads, sometimes anywhere in the field range
    task automatic queue_random_read(input bit idle_ok);
        if ($urandom_range(0, 99) < 85)
            queue_op(OP_READ, 8'($urandom), 7'($urandom_range(0, COLUMNS - 1)),
                     5'($urandom_range(0, ROWS - 1)), idle_ok);
        else
            queue_op(OP_READ, 8'($urandom), 7'($urandom_range(0, 127)),
                     5'($urandom_range(0, 31)), idle_ok);
    endtask

    // A line of text with random content, usually closed by a newline
    task automatic queue_line(input bit idle_ok);
        int len;
        int pick;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(70, 100) : $urandom_range(0, 20);
        for (int k = 0; k < len; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
                queue_op(OP_PUT, 8'($urandom_range(8'h20, 8'h7E)), 7'($urandom),
                         5'($urandom), idle_ok);
            else if (pick < 84)
                queue_op(OP_PUT, CH_BACKSPACE, '0, '0, idle_ok);
            else if (pick < 86)
                queue_op(OP_PUT, CH_RETURN, '0, '0, idle_ok);
            else if (pick < 92)
                queue_op(OP_PUT, 8'($urandom_range(0, 255)), '0, '0, idle_ok);
            else
                queue_random_read(idle_ok);
        end
        pick = $urandom_range(0, 99);
        if (pick < 85)
            queue_op(OP_PUT, CH_NEWLINE, '0, '0, idle_ok);
        else if (pick < 87)
            queue_op(OP_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom), idle_ok);
        else if (pick < 90)
            queue_op(OP_NONE, 8'($urandom), 7'($urandom), 5'($urandom), idle_ok);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(2, 4))
                queue_random_read(idle_ok);
    endtask

    // ---------------------------------------------------------------
    // Driver: inputs change on the falling edge
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                cfg_we <= 1'b0;
            else if (start && !took_item)
                ;   // transaction still waiting for the block
            else if (hold_cycles > 0)
            begin
                start <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end
            else if (console_cmds.size() == 0)
                start <= 1'b0;
            else
            begin
                head_cmd = console_cmds[0];
                case (head_cmd.kind)
                    STEP_GAP:
                    begin
                        start <= 1'b0;
                        hold_cycles <= int'(head_cmd.gap) - 1;
                        head_cmd = console_cmds.pop_front();
                    end
                    STEP_CFG:
                    begin
                        // attribute is written only with the block drained and idle
                        start <= 1'b0;
                        if (!start && expected_views.size() == 0 && !busy)
                        begin
                            cfg_we <= 1'b1;
                            cfg_wdata <= head_cmd.attr;
                            head_cmd = console_cmds.pop_front();
                        end
                    end
                    default:
                    begin
                        start <= 1'b1;
                        operation <= head_cmd.operation;
                        char_code <= head_cmd.char_code;
                        read_column <= head_cmd.read_column;
                        read_row <= head_cmd.read_row;
                        head_cmd = console_cmds.pop_front();
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: sample on the rising edge, check, then predict
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took_item <= start && !busy;
            if (cfg_we)
                attr_model = cfg_wdata;
            if (result_valid)
            begin
                seen_view = {cell_value, cursor_column, cursor_row};
                if (expected_views.size() == 0)
                    note_mismatch("unexpected result cell", 32'h0, 32'(cell_value));
                else
                begin
                    want_view = expected_views.pop_front();
                    if (seen_view.cell_val !== want_view.cell_val)
                        note_mismatch("cell_value", 32'(want_view.cell_val),
                                      32'(seen_view.cell_val));
                    if (seen_view.col !== want_view.col)
                        note_mismatch("cursor_column", 32'(want_view.col), 32'(seen_view.col));
                    if (seen_view.row !== want_view.row)
                        note_mismatch("cursor_row", 32'(want_view.row), 32'(seen_view.row));
                end
            end
            if (start && !busy)
            begin
                console_step(operation, char_code, read_column, read_row, want_view);
                expected_views.push_back(want_view);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit)
        begin
            $display("text_mode_terminal_writer_top_test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------
    initial
    begin
        logic [ATTR_W-1:0] phase_attr [0:PHASES-1];
        int phase_start;

        model_clear();
        attr_model = ATTR_RESET;

        // Directed part: field extremes, control codes and odd reads
        queue_op(OP_READ, '0, 7'd0, 5'd0, 1'b0);
        queue_op(OP_READ, '0, 7'(COLUMNS - 1), 5'(ROWS - 1), 1'b0);
        queue_op(OP_PUT, 8'h00, '0, '0, 1'b0);
        queue_op(OP_PUT, 8'hFF, 7'h7F, 5'h1F, 1'b0);
        queue_op(OP_PUT, 8'h41, '0, '0, 1'b0);
        queue_op(OP_PUT, CH_BACKSPACE, '0, '0, 1'b0);
        queue_op(OP_READ, '0, 7'd2, 5'd0, 1'b0);
        queue_op(OP_PUT, CH_RETURN, '0, '0, 1'b0);
        queue_op(OP_NONE, 8'hFF, 7'h7F, 5'h1F, 1'b0);
        queue_op(OP_PUT, CH_NEWLINE, '0, '0, 1'b0);
        // backspace at column zero lands as a character
        queue_op(OP_PUT, CH_BACKSPACE, '0, '0, 1'b0);
        queue_op(OP_READ, '0, 7'd0, 5'd1, 1'b0);
        queue_op(OP_READ, '0, 7'(COLUMNS), 5'd0, 1'b0);
        queue_op(OP_READ, '0, 7'd0, 5'(ROWS), 1'b0);
        queue_op(OP_READ, '0, 7'h7F, 5'h1F, 1'b0);
        queue_attr(8'h00);
        queue_op(OP_PUT, 8'h7A, '0, '0, 1'b0);
        queue_op(OP_READ, '0, 7'd1, 5'd1, 1'b0);
        queue_op(OP_CLEAR, '0, '0, '0, 1'b0);
        queue_op(OP_READ, '0, 7'd0, 5'd0, 1'b0);
        queue_op(OP_READ, '0, 7'd1, 5'd1, 1'b0);

        // Random part in phases, each under its own attribute
        phase_attr[0] = 8'hFF;
        phase_attr[1] = 8'($urandom);
        phase_attr[2] = 8'h00;
        phase_attr[3] = 8'($urandom);
        phase_attr[4] = ATTR_RESET;
        phase_attr[5] = 8'hFF;
        for (int p = 0; p < PHASES; p++)
        begin
            queue_attr(phase_attr[p]);
            phase_start = ops_queued;
            while (ops_queued - phase_start < PHASE_OPS)
                queue_line((p < PHASES - 1) && ($urandom_range(0, 3) != 0));
        end

        // Timeout from a slow bound: every put or clear taking a full pass
        cycle_limit = 2 * CELLS + TAIL_CYC + 100;
        foreach (console_cmds[i])
        begin
            case (console_cmds[i].kind)
                STEP_OP:
                    cycle_limit += (console_cmds[i].operation == OP_PUT ||
                                    console_cmds[i].operation == OP_CLEAR) ? CELLS + 10 : 10;
                STEP_GAP:
                    cycle_limit += int'(console_cmds[i].gap);
                default:
                    cycle_limit += 10;
            endcase
        end
        cycle_limit = 4 * cycle_limit;

        repeat (RESET_CYC) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (console_cmds.size() != 0 || start || cfg_we || hold_cycles != 0)
            @(posedge clk);
        while (expected_views.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);

        if (expected_views.size() != 0)
            note_mismatch("missing result count", 32'h0, 32'(expected_views.size()));
        if (mismatches == 0)
            $display("text_mode_terminal_writer_top_test passed");
        else
            $display("text_mode_terminal_writer_top_test failed");
        $finish;
    end

endmodule

`default_nettype wire
